/* design/scfr_pkg.sv */
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared constants and types for the serial frame receiver with CRC-16 check.
// ----------------------------------------------------------------------------
package scfr_pkg;

    // Largest payload length the design can ever accept, in bytes
    localparam int C_MAX_PAYLOAD = 58;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] C_CRC_POLY = 16'h1021;
    localparam logic [15:0] C_CRC_SEED = 16'hFFFF;

    // Configuration register indexes
    localparam logic C_REG_START_BYTE  = 1'b0;
    localparam logic C_REG_MAX_PAYLOAD = 1'b1;

    // Configuration register reset values
    localparam logic [7:0] C_START_BYTE_RST  = 8'hF8;
    localparam logic [5:0] C_MAX_PAYLOAD_RST = 6'd58;

    // Result kind codes
    localparam logic C_KIND_DATA   = 1'b0;
    localparam logic C_KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [1:0] C_ST_OK        = 2'd0;
    localparam logic [1:0] C_ST_BAD_START = 2'd1;
    localparam logic [1:0] C_ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] C_ST_BAD_CRC   = 2'd3;

    // One result word from the parser to the output register
    typedef struct packed {
        logic        emit;
        logic        kind;
        logic [7:0]  data_byte;
        logic [5:0]  byte_index;
        logic [7:0]  frame_opcode;
        logic [15:0] frame_length;
        logic [1:0]  status;
    } t_result;

endpackage

/* design/scfr_crc16.sv */
// ----------------------------------------------------------------------------
// scfr_crc16
// Byte-wide CRC-16/CCITT-FALSE update, MSB first, no reflection.
// ----------------------------------------------------------------------------
module scfr_crc16
    import scfr_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ C_CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

/* design/scfr_parser.sv */
// ----------------------------------------------------------------------------
// scfr_parser
// Frame phase sequencer: header capture, length check, payload indexing and
// CRC compare. Advances one byte per step.
// ----------------------------------------------------------------------------
module scfr_parser
    import scfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_start_byte,
    input  logic [5:0]    i_max_payload,
    output t_result       o_result
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_OPCODE = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CRC_HI = 3'd5;
    localparam logic [2:0] PH_CRC_LO = 3'd6;

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_opcode, n_opcode;
    logic [15:0] r_length, n_length;
    logic [5:0]  r_count,  n_count;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;

    logic [15:0] w_crc_upd;
    logic [7:0]  w_limit;
    logic [15:0] w_len_full;
    logic [5:0]  w_count_inc;
    t_result     w_res;

    scfr_crc16 u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (w_crc_upd)
    );

    // Smaller of the configured limit and the design limit
    assign w_limit = ({2'b00, i_max_payload} < 8'(C_MAX_PAYLOAD)) ?
                     {2'b00, i_max_payload} : 8'(C_MAX_PAYLOAD);
    assign w_len_full  = {i_byte, r_length[7:0]};
    assign w_count_inc = r_count + 6'd1;

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_length = r_length;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;

        w_res              = '0;
        w_res.kind         = C_KIND_STATUS;
        w_res.frame_opcode = r_opcode;
        w_res.frame_length = r_length;

        unique case (r_phase)
            PH_OPCODE: begin
                n_opcode = i_byte;
                n_crc    = w_crc_upd;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {8'h00, i_byte};
                n_crc    = w_crc_upd;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = w_len_full;
                n_crc    = w_crc_upd;
                n_count  = '0;
                if (w_len_full > {8'h00, w_limit}) begin
                    n_phase            = PH_HUNT;
                    w_res.emit         = 1'b1;
                    w_res.frame_length = w_len_full;
                    w_res.status       = C_ST_BAD_LEN;
                end else if (w_len_full == 16'd0) begin
                    n_phase = PH_CRC_HI;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc            = w_crc_upd;
                n_count          = w_count_inc;
                w_res.emit       = 1'b1;
                w_res.kind       = C_KIND_DATA;
                w_res.data_byte  = i_byte;
                w_res.byte_index = r_count;
                w_res.status     = C_ST_OK;
                if ({10'd0, w_count_inc} >= r_length) begin
                    n_phase = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                n_crc_hi = i_byte;
                n_phase  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_phase      = PH_HUNT;
                w_res.emit   = 1'b1;
                w_res.status = ({r_crc_hi, i_byte} == r_crc) ? C_ST_OK : C_ST_BAD_CRC;
            end
            default: begin
                // Hunting; the unused code lands here too
                n_phase = PH_HUNT;
                if (i_byte == i_start_byte) begin
                    n_opcode = '0;
                    n_length = '0;
                    n_count  = '0;
                    n_crc    = C_CRC_SEED;
                    n_crc_hi = '0;
                    n_phase  = PH_OPCODE;
                end else begin
                    w_res.emit         = 1'b1;
                    w_res.frame_opcode = '0;
                    w_res.frame_length = '0;
                    w_res.status       = C_ST_BAD_START;
                end
            end
        endcase
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_opcode <= '0;
            r_length <= '0;
            r_count  <= '0;
            r_crc    <= C_CRC_SEED;
            r_crc_hi <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_length <= n_length;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
        end
    end

endmodule

/* design/serial_frame_receiver_crc16_unit.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc16_unit
// Deframes a received byte stream: start byte, opcode, 16-bit length,
// payload and CRC-16/CCITT-FALSE; streams payload words and one status word
// per frame or per rejected byte.
// ----------------------------------------------------------------------------
// Path: input register, combinational parser step, then output register.
// Throughput: one byte per cycle while the output is not stalled, set by the
//   combinational byte CRC update and phase step between the two registers.
// Reset (i_rst_n low, synchronous): both registers empty, parser hunting,
//   CRC seeded to 0xFFFF, start byte 0xF8, max payload 58.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc16_unit
    import scfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte

    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] data_byte, [13:8] byte_index,
                                          // [21:14] frame_opcode,
                                          // [37:22] frame_length, [39:38] status
    output logic        o_m_axis_tuser,   // [0] kind

    // Configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    // Configuration registers
    logic [7:0]  r_start_byte;
    logic [5:0]  r_max_payload;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Output register
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_kind;

    logic        w_step;
    t_result     w_res;

    // Advance the parser whenever a word sits in the input register and the
    // output register is free or is being drained this cycle.
    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;

    // Configuration decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= C_START_BYTE_RST;
            r_max_payload <= C_MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_REG_START_BYTE:  r_start_byte  <= i_cfg_wdata;
                C_REG_MAX_PAYLOAD: r_max_payload <= i_cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // Input register: load on accept, drop once the parser has taken it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    scfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_byte        (r_in_byte),
        .i_start_byte  (r_start_byte),
        .i_max_payload (r_max_payload),
        .o_result      (w_res)
    );

    // Output register: hold until taken, load when the parser emits a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.emit) begin
            r_out_kind <= w_res.kind;
            r_out_data <= {w_res.status, w_res.frame_length, w_res.frame_opcode,
                           w_res.byte_index, w_res.data_byte};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;

endmodule
